/* src/teq_pkg.sv */
// Timed event queue package: sizes, register addresses, function and status codes, types.
// Used by every module under src and by the testbench; depends on nothing.
package teq_pkg;
	localparam int ENTRIES = 32;
	localparam int ID_BITS = 16;
	localparam int TIME_BITS = 48;
	localparam int IDX_BITS = $clog2(ENTRIES);
	localparam int CNT_BITS = $clog2(ENTRIES + 1);

	// APB byte addresses of the configuration registers
	localparam logic [2:0] ADDR_LOCK = 3'd0;
	localparam logic [2:0] ADDR_JITTER = 3'd4;

	typedef enum logic [2:0] {
		FN_REGISTER = 3'd0,
		FN_UNREGISTER = 3'd1,
		FN_SET_ABS = 3'd2,
		FN_SET_REL = 3'd3,
		FN_TICK = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_FULL = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [9:0] {
		S_IDLE = 10'b0000000001,
		S_FIND = 10'b0000000010,
		S_CHK = 10'b0000000100,
		S_RMV_RD = 10'b0000001000,
		S_RMV_WR = 10'b0000010000,
		S_SCAN = 10'b0000100000,
		S_CMP = 10'b0001000000,
		S_PUT = 10'b0010000000,
		S_HEAD = 10'b0100000000,
		S_OUT = 10'b1000000000
	} state_t;

	// One memory request: read and write ports of the entry store.
	typedef struct packed {
		logic                 rd_en;
		logic [IDX_BITS-1:0]  rd_addr;
		logic                 wr_en;
		logic [IDX_BITS-1:0]  wr_addr;
		logic [ID_BITS-1:0]   wr_obj;
		logic [TIME_BITS-1:0] wr_time;
	} mem_req_t;

	typedef struct packed {
		logic [ID_BITS-1:0]   obj;
		logic [TIME_BITS-1:0] tm;
	} entry_t;
endpackage

/* src/teq_entry_ram.sv */
// Entry store: one write port and one read port, registered read data.
// Depends on teq_pkg.
module teq_entry_ram
	import teq_pkg::*;
(
	input  logic     clk,
	input  mem_req_t req,
	output entry_t   rd_data
);
	entry_t mem [ENTRIES];

	// Write port and registered read port
	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= '{obj: req.wr_obj, tm: req.wr_time};
		end
		if (req.rd_en) begin
			rd_data <= mem[req.rd_addr];
		end
	end
endmodule

/* src/timed_event_queue_core.sv */
// Timed event queue top level: APB registers, sequencer over the entry store.
// Depends on teq_pkg and teq_entry_ram.
//
// channel | signals                                    | direction
// in      | in_valid/in_ready, func..now_time          | to block
// out     | out_valid/out_ready, status..exceed_count  | from block
// cfg     | psel penable pwrite paddr pwdata prdata    | APB slave
//
// One item at a time; each store step reads an entry, then judges it or writes it back.
// A find reads and judges the entries in turn, a removal moves each later entry up one
// place, an insert moves each later entry down one place and writes the new one; then
// the head is read and the output word is loaded. A move is a removal, then an insert.
// Reset clears the count, the late counter, the registers and the output word; the
// store is left unset. The next item is taken while a finished word waits at the output.
module timed_event_queue_core
	import teq_pkg::*;
(
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [2:0]                  func,
	input  logic [ID_BITS-1:0]          object_id,
	input  logic [TIME_BITS-1:0]        event_time,
	input  logic                        time_given,
	input  logic signed [TIME_BITS-1:0] time_span,
	input  logic [TIME_BITS-1:0]        now_time,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [1:0]                  status,
	output logic                        fired,
	output logic [ID_BITS-1:0]          fired_object,
	output logic [TIME_BITS-1:0]        wait_time,
	output logic                        no_event,
	output logic [31:0]                 exceed_count,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [2:0]                  paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);
	logic        lock_q;
	logic [31:0] jitter_q;
	logic [31:0] late_q;
	logic [CNT_BITS-1:0] count_q;

	state_t state_q;
	logic [2:0]           func_q;
	logic [ID_BITS-1:0]   obj_q;
	logic [TIME_BITS-1:0] tgt_q;
	logic [TIME_BITS-1:0] now_q;
	logic [IDX_BITS-1:0]  idx_q;
	logic [1:0]           stat_q;
	logic                 fired_q;

	mem_req_t req;
	entry_t   rd;

	teq_entry_ram u_ram (.clk(clk), .req(req), .rd_data(rd));

	// APB registers
	assign pready = 1'b1;
	always_comb begin
		case (paddr)
			ADDR_LOCK: prdata = {31'd0, lock_q};
			ADDR_JITTER: prdata = jitter_q;
			default: prdata = 32'd0;
		endcase
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lock_q <= 1'b0;
			jitter_q <= '0;
		end else if (psel && penable && pwrite) begin
			if (paddr == ADDR_LOCK) lock_q <= pwdata[0];
			if (paddr == ADDR_JITTER) jitter_q <= pwdata;
		end
	end

	// Target time for set relative: now plus span, clamped; for set absolute: event time if given, else now
	logic [TIME_BITS+1:0] rel_sum;
	logic [TIME_BITS-1:0] rel_t, abs_t;
	always_comb begin
		rel_sum = $signed({2'b00, now_time}) + $signed({{2{time_span[TIME_BITS-1]}}, time_span});
		if (rel_sum[TIME_BITS+1]) rel_t = '0;
		else if (rel_sum[TIME_BITS]) rel_t = '1;
		else rel_t = rel_sum[TIME_BITS-1:0];
		abs_t = time_given ? event_time : now_time;
	end

	logic out_free;
	assign out_free = !out_valid || out_ready;
	assign in_ready = (state_q == S_IDLE);

	logic [CNT_BITS-1:0] idx_ext, idx_inc, cnt_dec;
	assign idx_ext = CNT_BITS'(idx_q);
	assign idx_inc = idx_ext + CNT_BITS'(1);
	assign cnt_dec = count_q - CNT_BITS'(1);

	// Lateness of the head against the jitter limit
	logic [TIME_BITS-1:0] late_w;
	logic                 late_hit;
	assign late_w = now_q - rd.tm;
	assign late_hit = (jitter_q != 32'd0) && (late_w > {{(TIME_BITS-32){1'b0}}, jitter_q})
		&& (late_q != 32'hFFFF_FFFF);

	// Store requests per state
	always_comb begin
		req = '0;
		req.wr_obj = rd.obj;
		req.wr_time = rd.tm;
		case (state_q)
			S_FIND: begin
				req.rd_en = 1'b1;
				req.rd_addr = idx_q;
			end
			S_RMV_RD: begin
				// read entry idx+1 to move up
				req.rd_en = 1'b1;
				req.rd_addr = IDX_BITS'(idx_inc);
			end
			S_RMV_WR: begin
				req.wr_en = 1'b1;
				req.wr_addr = idx_q;
			end
			S_SCAN: begin
				// read entry idx-1 to compare with the target
				req.rd_en = (idx_q != '0);
				req.rd_addr = idx_q - IDX_BITS'(1);
			end
			S_CMP: begin
				// move a later entry down one place
				req.wr_en = (rd.tm > tgt_q);
				req.wr_addr = idx_q;
			end
			S_PUT: begin
				req.wr_en = 1'b1;
				req.wr_addr = idx_q;
				req.wr_obj = obj_q;
				req.wr_time = tgt_q;
			end
			S_HEAD: begin
				req.rd_en = 1'b1;
				req.rd_addr = '0;
			end
			default: ;
		endcase
	end

	// Sequencer: find, remove by shifting up, insert by shifting down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			late_q <= '0;
			func_q <= '0;
			obj_q <= '0;
			tgt_q <= '0;
			now_q <= '0;
			idx_q <= '0;
			stat_q <= ST_DONE;
			fired_q <= 1'b0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						func_q <= func;
						obj_q <= object_id;
						now_q <= now_time;
						fired_q <= 1'b0;
						tgt_q <= (func == FN_SET_REL) ? rel_t
							: (func == FN_SET_ABS) ? abs_t : now_time;
						case (func)
							FN_REGISTER: begin
								if (count_q >= CNT_BITS'(ENTRIES)) begin
									stat_q <= ST_FULL;
									idx_q <= '0;
									state_q <= S_HEAD;
								end else begin
									stat_q <= ST_DONE;
									idx_q <= IDX_BITS'(count_q);
									state_q <= S_SCAN;
								end
							end
							FN_UNREGISTER, FN_SET_ABS, FN_SET_REL: begin
								idx_q <= '0;
								if (count_q == '0) begin
									stat_q <= ST_NOT_FOUND;
									state_q <= S_HEAD;
								end else begin
									stat_q <= ST_DONE;
									state_q <= S_FIND;
								end
							end
							FN_TICK: begin
								idx_q <= '0;
								stat_q <= ST_DONE;
								if (lock_q || count_q == '0) state_q <= S_HEAD;
								else state_q <= S_FIND;
							end
							default: begin
								idx_q <= '0;
								stat_q <= ST_DONE;
								state_q <= S_HEAD;
							end
						endcase
					end
				end
				S_FIND: begin
					// data of entry idx arrives next cycle
					state_q <= S_CHK;
				end
				S_CHK: begin
					if (func_q == FN_TICK) begin
						// fire the head when its time is before now
						if (rd.tm < now_q) begin
							fired_q <= 1'b1;
							obj_q <= rd.obj;
							if (late_hit) late_q <= late_q + 32'd1;
							state_q <= S_RMV_RD;
						end else begin
							state_q <= S_HEAD;
						end
					end else if (rd.obj == obj_q) begin
						state_q <= S_RMV_RD;
					end else if (idx_inc < count_q) begin
						idx_q <= idx_q + IDX_BITS'(1);
						state_q <= S_FIND;
					end else begin
						stat_q <= ST_NOT_FOUND;
						state_q <= S_HEAD;
					end
				end
				S_RMV_RD: begin
					if (idx_inc < count_q) begin
						state_q <= S_RMV_WR;
					end else begin
						// last entry reached: drop it from the count
						count_q <= cnt_dec;
						if (func_q == FN_UNREGISTER) begin
							state_q <= S_HEAD;
						end else begin
							idx_q <= IDX_BITS'(cnt_dec);
							state_q <= S_SCAN;
						end
					end
				end
				S_RMV_WR: begin
					idx_q <= idx_q + IDX_BITS'(1);
					state_q <= S_RMV_RD;
				end
				S_SCAN: begin
					state_q <= (idx_q == '0) ? S_PUT : S_CMP;
				end
				S_CMP: begin
					if (rd.tm > tgt_q) begin
						idx_q <= idx_q - IDX_BITS'(1);
						state_q <= S_SCAN;
					end else begin
						state_q <= S_PUT;
					end
				end
				S_PUT: begin
					count_q <= count_q + CNT_BITS'(1);
					state_q <= S_HEAD;
				end
				S_HEAD: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_free) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Output word register: load from the head read, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			status <= '0;
			fired <= 1'b0;
			fired_object <= '0;
			wait_time <= '0;
			no_event <= 1'b0;
			exceed_count <= '0;
		end else if (state_q == S_OUT && out_free) begin
			out_valid <= 1'b1;
			status <= stat_q;
			fired <= fired_q;
			fired_object <= fired_q ? obj_q : '0;
			exceed_count <= late_q;
			no_event <= lock_q || (count_q == '0);
			wait_time <= (!lock_q && count_q != '0 && rd.tm > now_q) ? rd.tm - now_q : '0;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end
endmodule

/* tb/sv/tb_timed_event_queue_core.sv */
// Testbench for timed_event_queue_core: directed and random operations, checked
// against a behavioral model of the sorted event table. Depends on teq_pkg and timed_event_queue_core.
`timescale 1ns / 100ps

module tb_timed_event_queue_core
	import teq_pkg::*;
();
	localparam logic [TIME_BITS-1:0] TMAX = '1;
	localparam longint unsigned CYCLE_LIMIT = 2000000;

	typedef struct {
		logic [1:0]           status;
		logic                 fired;
		logic [ID_BITS-1:0]   fired_object;
		logic [TIME_BITS-1:0] wait_time;
		logic                 no_event;
		logic [31:0]          exceed_count;
	} event_word_t;

	// Scoreboard: event table model plus queue of expected result words
	class event_table_board;
		logic [ID_BITS-1:0]   obj_q[$];
		logic [TIME_BITS-1:0] time_q[$];
		logic [31:0]          late_count;
		logic                 lock;
		logic [31:0]          jitter;
		event_word_t          pending[$];
		int                   errors;

		function new();
			late_count = 0;
			lock = 0;
			jitter = 0;
			errors = 0;
		endfunction

		function void place(logic [ID_BITS-1:0] o, logic [TIME_BITS-1:0] t);
			int p;
			p = 0;
			while (p < time_q.size() && time_q[p] <= t)
				p++;
			obj_q.insert(p, o);
			time_q.insert(p, t);
		endfunction

		function int locate(logic [ID_BITS-1:0] o);
			foreach (obj_q[k])
				if (obj_q[k] == o)
					return k;
			return -1;
		endfunction

		function logic [1:0] relocate(logic [ID_BITS-1:0] o, logic [TIME_BITS-1:0] t);
			int k;
			k = locate(o);
			if (k < 0)
				return ST_NOT_FOUND;
			obj_q.delete(k);
			time_q.delete(k);
			place(o, t);
			return ST_DONE;
		endfunction

		// Apply one accepted word and queue the result it causes
		function void note_input(logic [2:0] fn, logic [ID_BITS-1:0] o,
				logic [TIME_BITS-1:0] evt, logic given, logic [TIME_BITS-1:0] span,
				logic [TIME_BITS-1:0] now);
			event_word_t w;
			logic [TIME_BITS-1:0] mag;
			logic [TIME_BITS:0] sum;
			logic [TIME_BITS-1:0] t;
			logic [TIME_BITS-1:0] late;
			logic [ID_BITS-1:0] head;
			int k;
			w = '{default: 0};
			case (fn)
				FN_REGISTER: begin
					if (obj_q.size() >= ENTRIES)
						w.status = ST_FULL;
					else
						place(o, now);
				end
				FN_UNREGISTER: begin
					k = locate(o);
					if (k < 0)
						w.status = ST_NOT_FOUND;
					else begin
						obj_q.delete(k);
						time_q.delete(k);
					end
				end
				FN_SET_ABS: w.status = relocate(o, given ? evt : now);
				FN_SET_REL: begin
					if (span[TIME_BITS-1]) begin
						mag = -span;
						t = (now >= mag) ? now - mag : '0;
					end else begin
						sum = now + span;
						t = sum[TIME_BITS] ? TMAX : sum[TIME_BITS-1:0];
					end
					w.status = relocate(o, t);
				end
				FN_TICK: begin
					if (!lock && obj_q.size() > 0 && time_q[0] < now) begin
						late = now - time_q[0];
						head = obj_q[0];
						if (jitter != 0 && late > jitter && late_count != 32'hFFFFFFFF)
							late_count++;
						obj_q.delete(0);
						time_q.delete(0);
						place(head, now);
						w.fired = 1;
						w.fired_object = head;
					end
				end
				default: ;
			endcase
			if (lock || obj_q.size() == 0)
				w.no_event = 1;
			else if (time_q[0] > now)
				w.wait_time = time_q[0] - now;
			w.exceed_count = late_count;
			pending.push_back(w);
		endfunction

		// Compare one accepted result word with the oldest expectation
		function void check_result(event_word_t got);
			event_word_t e;
			if (pending.size() == 0) begin
				$display("%0t: result word exp none got status=%0d", $time, got.status);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.status !== e.status) begin
				$display("%0t: status exp %0d got %0d", $time, e.status, got.status);
				errors++;
			end
			if (got.fired !== e.fired) begin
				$display("%0t: fired exp %0d got %0d", $time, e.fired, got.fired);
				errors++;
			end
			if (got.fired_object !== e.fired_object) begin
				$display("%0t: fired_object exp %0h got %0h", $time, e.fired_object,
					got.fired_object);
				errors++;
			end
			if (got.wait_time !== e.wait_time) begin
				$display("%0t: wait_time exp %0h got %0h", $time, e.wait_time, got.wait_time);
				errors++;
			end
			if (got.no_event !== e.no_event) begin
				$display("%0t: no_event exp %0d got %0d", $time, e.no_event, got.no_event);
				errors++;
			end
			if (got.exceed_count !== e.exceed_count) begin
				$display("%0t: exceed_count exp %0h got %0h", $time, e.exceed_count,
					got.exceed_count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_ready;
	logic [2:0] func = '0;
	logic [ID_BITS-1:0] object_id = '0;
	logic [TIME_BITS-1:0] event_time = '0;
	logic time_given = 0;
	logic signed [TIME_BITS-1:0] time_span = '0;
	logic [TIME_BITS-1:0] now_time = '0;
	logic out_valid;
	logic out_ready = 0;
	logic [1:0] status;
	logic fired;
	logic [ID_BITS-1:0] fired_object;
	logic [TIME_BITS-1:0] wait_time;
	logic no_event;
	logic [31:0] exceed_count;
	logic psel = 0;
	logic penable = 0;
	logic pwrite = 0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	event_table_board board = new();
	logic [TIME_BITS-1:0] clock_now = 48'd1000;
	logic [ID_BITS-1:0] id_pool[8];
	int idle_pct_in = 12;
	int idle_pct_out = 12;
	int hold_cycles = 0;
	longint unsigned cycles = 0;

	timed_event_queue_core uut (.*);

	always #1 clk = ~clk;

	// Limit the run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Drain results with random stalls and an optional long hold-off
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_result('{status, fired, fired_object, wait_time, no_event,
				exceed_count});
		if (hold_cycles > 0) begin
			hold_cycles <= hold_cycles - 1;
			out_ready <= 0;
		end else
			out_ready <= ($urandom_range(99) >= idle_pct_out);
	end

	task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
		psel <= 1;
		penable <= 0;
		pwrite <= 1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1;
		@(posedge clk);
		psel <= 0;
		penable <= 0;
		pwrite <= 0;
		if (addr == ADDR_LOCK)
			board.lock = data[0];
		else
			board.jitter = data;
		@(posedge clk);
	endtask

	// Offer one word and hold it until accepted
	task automatic send_word(input logic [2:0] fn, input logic [ID_BITS-1:0] o,
			input logic [TIME_BITS-1:0] evt, input logic given,
			input logic [TIME_BITS-1:0] span, input logic [TIME_BITS-1:0] now);
		while ($urandom_range(99) < idle_pct_in) begin
			in_valid <= 0;
			@(posedge clk);
		end
		in_valid <= 1;
		func <= fn;
		object_id <= o;
		event_time <= evt;
		time_given <= given;
		time_span <= span;
		now_time <= now;
		do
			@(posedge clk);
		while (!in_ready);
		board.note_input(fn, o, evt, given, span, now);
	endtask

	task automatic wait_drained();
		in_valid <= 0;
		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	// Random operation: mostly on a small pool of ids, advancing time
	task automatic random_word();
		logic [2:0] fn;
		logic [ID_BITS-1:0] o;
		logic [TIME_BITS-1:0] span;
		int r;
		r = $urandom_range(99);
		fn = (r < 25) ? FN_REGISTER : (r < 35) ? FN_UNREGISTER : (r < 50) ? FN_SET_ABS :
			(r < 65) ? FN_SET_REL : (r < 97) ? FN_TICK : 3'($urandom_range(7, 5));
		o = ($urandom_range(9) == 0) ? 16'($urandom) : id_pool[$urandom_range(7)];
		if ($urandom_range(1))
			clock_now = clock_now + $urandom_range(3000);
		if ($urandom_range(19) == 0)
			span = {16'($urandom), $urandom};
		else
			span = 48'(signed'($urandom_range(4000)) - 2000);
		send_word(fn, o, ($urandom_range(9) == 0) ? {16'($urandom), $urandom} :
			clock_now + $urandom_range(5000) - 2500, 1'($urandom_range(1)), span, clock_now);
	endtask

	initial begin
		foreach (id_pool[k])
			id_pool[k] = 16'($urandom);
		id_pool[0] = '0;
		id_pool[1] = 16'hFFFF;
		repeat (10) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		apb_write(ADDR_JITTER, 32'd100);

		// Directed: empty queue, missing objects, extremes, full table
		send_word(FN_TICK, 0, 0, 0, 0, 0);
		send_word(FN_UNREGISTER, 16'hFFFF, 0, 0, 0, 5);
		send_word(FN_SET_ABS, 7, 0, 1, 0, 5);
		send_word(FN_REGISTER, 16'h0000, 0, 0, 0, 10);
		send_word(FN_REGISTER, 16'hFFFF, 0, 0, 0, 10);
		send_word(FN_REGISTER, 16'hFFFF, 0, 0, 0, 10);
		send_word(FN_SET_ABS, 16'hFFFF, TMAX, 1, 0, 20);
		send_word(FN_SET_ABS, 16'h0000, 0, 0, 0, 20);
		send_word(FN_SET_REL, 16'hFFFF, 0, 0, 48'h7FFF_FFFF_FFFF, 30);
		send_word(FN_SET_REL, 16'hFFFF, 0, 0, 48'h8000_0000_0000, 30);
		send_word(FN_SET_REL, 16'h0000, 0, 0, 48'hFFFF_FFFF_FFFF, 30);
		send_word(FN_TICK, 0, 0, 0, 0, 30);
		send_word(FN_TICK, 0, 0, 0, 0, 1000);
		send_word(3'd5, 0, 0, 0, 0, 1000);
		send_word(3'd7, 16'hFFFF, TMAX, 1, 48'hFFFF_FFFF_FFFF, TMAX);
		send_word(FN_UNREGISTER, 16'hFFFF, 0, 0, 0, 1000);
		for (int k = 0; k < ENTRIES + 1; k++)
			send_word(FN_REGISTER, 16'(k), 0, 0, 0, 48'(2000 + k));
		send_word(FN_TICK, 0, 0, 0, 0, TMAX);
		wait_drained();

		// Lock set: ticks fire nothing
		apb_write(ADDR_LOCK, 32'd1);
		send_word(FN_TICK, 0, 0, 0, 0, TMAX);
		send_word(FN_UNREGISTER, 3, 0, 0, 0, TMAX);
		wait_drained();
		apb_write(ADDR_LOCK, 32'd0);
		apb_write(ADDR_JITTER, 32'hFFFF_FFFF);
		for (int k = 0; k < ENTRIES; k++)
			send_word(FN_UNREGISTER, 16'(k), 0, 0, 0, 0);
		wait_drained();

		// Random phases across settings; long receiver hold-off in the first
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: apb_write(ADDR_JITTER, 32'd0);
				1: apb_write(ADDR_JITTER, 32'd500);
				2: apb_write(ADDR_JITTER, 32'd1);
				default: begin
					apb_write(ADDR_LOCK, 32'd1);
					apb_write(ADDR_JITTER, 32'hFFFF_FFFF);
				end
			endcase
			if (ph == 0)
				hold_cycles = 400;
			idle_pct_in = (ph == 1) ? 0 : 12;
			idle_pct_out = (ph == 1) ? 0 : 12;
			for (int k = 0; k < 250; k++)
				random_word();
			wait_drained();
		end

		if (board.errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end
endmodule
